// ----- hw/rtl/scla_pkg.sv -----
`default_nettype none
package scla_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int ADDR_W     = IDX_W + 1;
  localparam int MEM_DEPTH  = 1 << ADDR_W;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_POLL = 2'd2;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic take_byte;
    logic start_read;
    logic start_poll;
    logic start_empty;
    logic load_byte;
    logic load_end;
  } scla_ctl_t;

  typedef struct packed {
    logic cmd_ready;
    logic slot_free;
    logic more;
  } scla_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/scla_if.sv -----
`default_nettype none
interface scla_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;
  logic [7:0] read_limit;

  modport source (output valid, output cmd, output rx_byte, output read_limit, input ready);
  modport sink   (input valid, input cmd, input rx_byte, input read_limit, output ready);
endinterface

interface scla_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_command;
  logic       is_last;

  modport source (output valid, output out_byte, output has_command, output is_last,
                  input ready);
  modport sink   (input valid, input out_byte, input has_command, input is_last,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/scla_ctrl.sv -----
`default_nettype none
module scla_ctrl
  import scla_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_cmd,
  input  wire logic       limit_zero,
  input  wire scla_sts_t  sts,
  output logic            in_ready,
  output scla_ctl_t       ctl
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_STATUS  = 4'b0010,
    S_RD_ADDR = 4'b0100,
    S_RD_DATA = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_cmd)
            CMD_BYTE: ctl.take_byte = 1'b1;
            CMD_READ: begin
              if (!limit_zero && sts.cmd_ready) begin
                ctl.start_read = 1'b1;
                state_nxt      = S_RD_ADDR;
              end else begin
                ctl.start_empty = 1'b1;
                state_nxt       = S_STATUS;
              end
            end
            CMD_POLL: begin
              ctl.start_poll = 1'b1;
              state_nxt      = S_STATUS;
            end
            default: ;
          endcase
        end
      end
      S_STATUS: begin
        if (sts.slot_free) begin
          ctl.load_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD_ADDR: state_nxt = S_RD_DATA;
      S_RD_DATA: begin
        if (sts.slot_free) begin
          if (sts.more) begin
            ctl.load_byte = 1'b1;
            state_nxt     = S_RD_ADDR;
          end else begin
            ctl.load_end = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/scla_dp.sv -----
`default_nettype none
module scla_dp
  import scla_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] read_limit,
  input  wire scla_ctl_t  ctl,
  output scla_sts_t       sts,
  scla_out_if.source      out_ch
);

  logic [7:0] mem [0:MEM_DEPTH-1];
  logic [7:0] mem_q;

  idx_t       line_idx_r;
  idx_t       cmd_len_r;
  logic       cmd_ready_r;
  logic       line_bank_r;
  idx_t       rd_idx_r;
  idx_t       n_r;
  logic       has_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       has_out_r;
  logic       last_r;

  logic       is_eol;
  logic       room;
  logic [7:0] lim_m1;
  idx_t       n_nxt;
  logic       slot_free;

  assign is_eol    = (rx_byte == BYTE_LF) || (rx_byte == BYTE_CR);
  assign room      = line_idx_r < IDX_W'(LINE_DEPTH - 1);
  assign lim_m1    = read_limit - 8'd1;
  assign n_nxt     = (8'(cmd_len_r) < lim_m1) ? cmd_len_r : IDX_W'(lim_m1);
  assign slot_free = !out_valid_r || out_ch.ready;

  assign sts.cmd_ready = cmd_ready_r;
  assign sts.slot_free = slot_free;
  assign sts.more      = (rd_idx_r < n_r) && (mem_q != 8'd0);

  // line bank and command bank swap when a line is committed
  always_ff @(posedge clk) begin
    if (ctl.take_byte && !is_eol && room) begin
      mem[{line_bank_r, line_idx_r}] <= rx_byte;
    end
    mem_q <= mem[{~line_bank_r, rd_idx_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_idx_r  <= '0;
      cmd_len_r   <= '0;
      cmd_ready_r <= 1'b0;
      line_bank_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.take_byte) begin
        if (is_eol) begin
          if (line_idx_r != '0 && !cmd_ready_r) begin
            cmd_len_r   <= line_idx_r;
            cmd_ready_r <= 1'b1;
            line_bank_r <= ~line_bank_r;
          end
          line_idx_r <= '0;
        end else if (room) begin
          line_idx_r <= line_idx_r + 1'b1;
        end else begin
          line_idx_r <= '0;
        end
      end
      if (ctl.start_read || ctl.start_poll) begin
        cmd_ready_r <= 1'b0;
      end
      if (ctl.load_byte || ctl.load_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_read) begin
      rd_idx_r <= '0;
      n_r      <= n_nxt;
      has_r    <= 1'b1;
    end
    if (ctl.start_poll) begin
      has_r <= cmd_ready_r;
    end
    if (ctl.start_empty) begin
      has_r <= 1'b0;
    end
    if (ctl.load_byte) begin
      rd_idx_r   <= rd_idx_r + 1'b1;
      out_byte_r <= mem_q;
      has_out_r  <= 1'b1;
      last_r     <= 1'b0;
    end
    if (ctl.load_end) begin
      out_byte_r <= 8'd0;
      has_out_r  <= has_r;
      last_r     <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.has_command = has_out_r;
  assign out_ch.is_last     = last_r;

  a_ready_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_ready_r |-> cmd_len_r != '0)
    else $error("pending command with zero length");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start_read |=> !cmd_ready_r)
    else $error("read did not clear ready");

  a_byte_item: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_byte |=> out_valid_r && out_byte_r != 8'd0 && !last_r && has_out_r)
    else $error("bad command byte beat");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load_byte || ctl.load_end) |-> slot_free)
    else $error("output beat overwritten");

endmodule
`default_nettype wire

// ----- hw/rtl/serial_command_line_assembler.sv -----
// received byte: accepted in the idle state, no result beat
// poll or status read: status state registers the result beat once output is free
// command read: per command byte, a line memory read, then the output register;
//   the closing zero beat takes the same steps; one item in flight at a time
// sync active-low reset: line state, ready flag, output valid cleared; memory kept
`default_nettype none
module serial_command_line_assembler
  import scla_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  scla_in_if.sink    in_ch,
  scla_out_if.source out_ch
);

  scla_ctl_t ctl;
  scla_sts_t sts;
  logic      ready;

  scla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_cmd     (in_ch.cmd),
    .limit_zero (in_ch.read_limit == 8'd0),
    .sts        (sts),
    .in_ready   (ready),
    .ctl        (ctl)
  );

  scla_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_byte    (in_ch.rx_byte),
    .read_limit (in_ch.read_limit),
    .ctl        (ctl),
    .sts        (sts),
    .out_ch     (out_ch)
  );

  assign in_ch.ready = ready;

endmodule
`default_nettype wire
